// ===== hdl/ccdf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ccdf_pkg
// Shared types and constants of the checked command deframer.
// ----------------------------------------------------------------------------
package ccdf_pkg;

  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned PLEN_W       = 6;
  localparam int unsigned STATUS_W     = 3;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CNT_W        = 9;
  localparam int unsigned MAX_PAYLOAD_DEF = 32;

  localparam logic [15:0]       CRC_INIT  = 16'hFFFF;
  localparam logic [15:0]       CRC_POLY  = 16'hA001;
  localparam logic [CNT_W-1:0]  MIN_FRAME = 9'd5;
  localparam logic [CNT_W-1:0]  COUNT_MAX = 9'd511;
  localparam logic [CNT_W-1:0]  MAX_FRAME = 9'd255;

  localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hAA;
  localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h55;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 3'd0,
    ST_SHORT  = 3'd1,
    ST_SYNC   = 3'd2,
    ST_LENGTH = 3'd3,
    ST_LONG   = 3'd4,
    ST_CRC    = 3'd5
  } status_e;

endpackage
`default_nettype wire

// ===== hdl/ccdf_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ccdf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ccdf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/crc16_checked_command_deframer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// crc16_checked_command_deframer
// Sync/length/command framed byte stream with a CRC-16/MODBUS trailer.
// ----------------------------------------------------------------------------
// Input beats carry one frame byte and a flag on the frame's final byte.
// Every byte is folded into the CRC one bit per cycle, two bytes behind
// the input so that the trailing CRC bytes stay out of the sum. A byte
// therefore occupies the block until its bit-serial CRC loop is done: the
// next byte may be taken on the last CRC cycle of the previous one. After
// the final byte's CRC loop, the S_CHK state checks the frame and registers
// the header beat. For a good frame the header is followed by the payload
// beats; each waits for the previous one to be taken, then is read from the
// RAM and registered. While a frame's results are being delivered no input
// is taken; a stalled output beat simply holds. Payload bytes live in a
// small RAM that needs no clearing. Reset returns the sync registers to
// 0xAA and 0x55 and empties any partial frame. Configuration writes are
// always ready and take effect on the next byte.
// ----------------------------------------------------------------------------
module crc16_checked_command_deframer #(
  parameter int unsigned MAX_PAYLOAD = ccdf_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [ccdf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [ccdf_pkg::BYTE_W-1:0]     cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [ccdf_pkg::BYTE_W-1:0]     data_byte_i,
  input  wire logic                            frame_end_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic                                 is_header_o,
  output logic      [ccdf_pkg::STATUS_W-1:0]   status_o,
  output logic      [ccdf_pkg::BYTE_W-1:0]     command_o,
  output logic      [ccdf_pkg::PLEN_W-1:0]     payload_length_o,
  output logic      [ccdf_pkg::BYTE_W-1:0]     payload_byte_o,
  output logic                                 last_of_run_o
);
  import ccdf_pkg::*;

  localparam int unsigned AddrW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [CNT_W:0] StoreEnd = (CNT_W+1)'(4 + MAX_PAYLOAD);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CRC,
    S_CHK,
    S_OUT,
    S_LOAD
  } state_e;

  state_e               state_q;
  logic [BYTE_W-1:0]    sync_first_q, sync_second_q;
  logic [15:0]          crc_q, crc_d;
  logic [15:0]          tail_q;
  logic [BYTE_W-1:0]    feed_q;
  logic [2:0]           bit_q;
  logic                 crc_en_q;
  logic                 end_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 sync_ok_q;
  logic [BYTE_W-1:0]    len_q;
  logic [BYTE_W-1:0]    cmd_q;
  logic [PLEN_W-1:0]    plen_cnt_q;
  logic [PLEN_W-1:0]    sent_q;

  logic                 out_valid_q;
  logic                 is_header_q;
  status_e              status_q;
  logic [BYTE_W-1:0]    command_q;
  logic [PLEN_W-1:0]    payload_length_q;
  logic [BYTE_W-1:0]    payload_byte_q;
  logic                 last_q;

  logic                 in_acc, out_acc, take_ok;
  logic                 ram_we, ram_re;
  logic [AddrW-1:0]     ram_waddr;
  logic [BYTE_W-1:0]    ram_rdata;
  status_e              st_c;
  logic [CNT_W-1:0]     len_ext, plen_c;
  logic [15:0]          recv_crc;

  // A new byte may enter while idle, or on the last CRC cycle of a byte that
  // does not end the frame.
  assign take_ok    = (state_q == S_IDLE) ||
                      (state_q == S_CRC && bit_q == 3'd7 && !end_q);
  assign in_stall_o = !take_ok;
  assign in_acc     = in_valid_i && take_ok;
  assign out_acc    = out_valid_q && !out_stall_i;
  assign cfg_ready_o = 1'b1;

  // One reflected CRC step per cycle, LSB of the feed byte first.
  always_comb begin
    if (crc_q[0] ^ feed_q[0]) begin
      crc_d = (crc_q >> 1) ^ CRC_POLY;
    end else begin
      crc_d = crc_q >> 1;
    end
  end

  assign ram_we    = in_acc && (cnt_q >= 9'd4) && ({1'b0, cnt_q} < StoreEnd);
  assign ram_waddr = AddrW'(cnt_q - 9'd4);
  assign ram_re    = (state_q == S_OUT) && out_acc && !last_q;

  ccdf_ram #(
    .Width (BYTE_W),
    .Depth (MAX_PAYLOAD),
    .AddrW (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (data_byte_i),
    .re_i    (ram_re),
    .raddr_i (sent_q[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Frame checks, in priority order.
  assign len_ext  = {1'b0, len_q};
  assign plen_c   = len_ext - 9'd1;
  assign recv_crc = {tail_q[7:0], tail_q[15:8]};

  always_comb begin
    priority if (cnt_q < MIN_FRAME) begin
      st_c = ST_SHORT;
    end else if (!sync_ok_q) begin
      st_c = ST_SYNC;
    end else if (len_q == '0 || cnt_q > MAX_FRAME || cnt_q != len_ext + MIN_FRAME) begin
      st_c = ST_LENGTH;
    end else if (plen_c > CNT_W'(MAX_PAYLOAD)) begin
      st_c = ST_LONG;
    end else if (crc_q != recv_crc) begin
      st_c = ST_CRC;
    end else begin
      st_c = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= S_IDLE;
      sync_first_q     <= SYNC_FIRST_RST;
      sync_second_q    <= SYNC_SECOND_RST;
      crc_q            <= CRC_INIT;
      tail_q           <= '0;
      feed_q           <= '0;
      bit_q            <= '0;
      crc_en_q         <= 1'b0;
      end_q            <= 1'b0;
      cnt_q            <= '0;
      sync_ok_q        <= 1'b1;
      len_q            <= '0;
      cmd_q            <= '0;
      plen_cnt_q       <= '0;
      sent_q           <= '0;
      out_valid_q      <= 1'b0;
      is_header_q      <= 1'b0;
      status_q         <= ST_OK;
      command_q        <= '0;
      payload_length_q <= '0;
      payload_byte_q   <= '0;
      last_q           <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_SYNC_FIRST:  sync_first_q  <= cfg_data_i;
          CFG_SYNC_SECOND: sync_second_q <= cfg_data_i;
          default: ;
        endcase
      end

      unique case (state_q)
        S_IDLE: ;
        S_CRC: begin
          if (crc_en_q) begin
            crc_q <= crc_d;
          end
          feed_q <= feed_q >> 1;
          bit_q  <= bit_q + 3'd1;
          if (bit_q == 3'd7) begin
            state_q <= end_q ? S_CHK : S_IDLE;
          end
        end
        S_CHK: begin
          out_valid_q      <= 1'b1;
          is_header_q      <= 1'b1;
          status_q         <= st_c;
          command_q        <= (st_c == ST_OK) ? cmd_q : '0;
          payload_length_q <= (st_c == ST_OK) ? PLEN_W'(plen_c) : '0;
          payload_byte_q   <= '0;
          last_q           <= (st_c != ST_OK) || (plen_c == '0);
          plen_cnt_q       <= (st_c == ST_OK) ? PLEN_W'(plen_c) : '0;
          sent_q           <= '0;
          // The header is captured in the output registers, the payload in the RAM; start over.
          crc_q     <= CRC_INIT;
          tail_q    <= '0;
          cnt_q     <= '0;
          sync_ok_q <= 1'b1;
          len_q     <= '0;
          cmd_q     <= '0;
          end_q     <= 1'b0;
          state_q   <= S_OUT;
        end
        S_OUT: begin
          if (out_acc) begin
            out_valid_q <= 1'b0;
            if (last_q) begin
              state_q <= S_IDLE;
            end else begin
              sent_q  <= sent_q + PLEN_W'(1);
              state_q <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          out_valid_q      <= 1'b1;
          is_header_q      <= 1'b0;
          status_q         <= ST_OK;
          command_q        <= '0;
          payload_length_q <= '0;
          payload_byte_q   <= ram_rdata;
          last_q           <= (sent_q == plen_cnt_q);
          state_q          <= S_OUT;
        end
        default: state_q <= S_IDLE;
      endcase

      if (in_acc) begin
        if (cnt_q != COUNT_MAX) begin
          cnt_q <= cnt_q + 9'd1;
        end
        tail_q   <= {tail_q[7:0], data_byte_i};
        feed_q   <= tail_q[15:8];
        crc_en_q <= (cnt_q >= 9'd2);
        bit_q    <= '0;
        end_q    <= frame_end_i;
        if (cnt_q == 9'd0 && data_byte_i != sync_first_q) begin
          sync_ok_q <= 1'b0;
        end
        if (cnt_q == 9'd1 && data_byte_i != sync_second_q) begin
          sync_ok_q <= 1'b0;
        end
        if (cnt_q == 9'd2) begin
          len_q <= data_byte_i;
        end
        if (cnt_q == 9'd3) begin
          cmd_q <= data_byte_i;
        end
        state_q <= S_CRC;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign is_header_o      = is_header_q;
  assign status_o         = status_q;
  assign command_o        = command_q;
  assign payload_length_o = payload_length_q;
  assign payload_byte_o   = payload_byte_q;
  assign last_of_run_o    = last_q;

  // No input byte is taken while a result is on offer.
  a_no_input_while_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input accepted while a result is pending");

  // An accepted byte always holds off the input as its CRC loop begins.
  a_byte_occupies: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("byte accepted without CRC cycles");

  // A failing header closes the frame's results.
  a_fail_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_header_o && status_o != ST_OK) |-> last_of_run_o)
    else $error("failing header not marked last");

  // Payload beats never carry header information.
  a_payload_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !is_header_o) |-> (status_o == ST_OK && payload_length_o == '0))
    else $error("payload beat carries header fields");

endmodule
`default_nettype wire
